[hw/rtl/chm_pkg.sv]
// chm_pkg: shared codes and the command/status structs for the hash map core
// used by chm_ctrl, chm_dpath and chained_hash_map_with_sorted_keys_core
// no dependencies
package chm_pkg;

    // operation codes on the func field
    localparam logic [1:0] FN_FIND  = 2'd0;
    localparam logic [1:0] FN_ENTER = 2'd1;
    localparam logic [1:0] FN_REMOVE = 2'd2;
    localparam logic [1:0] FN_READ  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    // datapath micro-operations
    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LOAD     = 5'd1;
    localparam logic [4:0] OP_DIV      = 5'd2;
    localparam logic [4:0] OP_HEAD_RD  = 5'd3;
    localparam logic [4:0] OP_HEAD_TAKE = 5'd4;
    localparam logic [4:0] OP_ENT_RD   = 5'd5;
    localparam logic [4:0] OP_ENT_CHK  = 5'd6;
    localparam logic [4:0] OP_ALLOC_RD = 5'd7;
    localparam logic [4:0] OP_ALLOC    = 5'd8;
    localparam logic [4:0] OP_SRT_RD   = 5'd9;
    localparam logic [4:0] OP_INS_CHK  = 5'd10;
    localparam logic [4:0] OP_INS_PUT  = 5'd11;
    localparam logic [4:0] OP_UNLINK   = 5'd12;
    localparam logic [4:0] OP_SRT_RD_I = 5'd13;
    localparam logic [4:0] OP_SRCH_CHK = 5'd14;
    localparam logic [4:0] OP_SRT_RD_N = 5'd15;
    localparam logic [4:0] OP_SHIFT_DN = 5'd16;
    localparam logic [4:0] OP_DEC      = 5'd17;
    localparam logic [4:0] OP_POS_RD   = 5'd18;
    localparam logic [4:0] OP_POS_TAKE = 5'd19;
    localparam logic [4:0] OP_DONE     = 5'd20;

    // controller to datapath
    typedef struct packed {
        logic [4:0] op;
        logic       cfg_we;
        logic       res_found;
        logic [2:0] res_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       div_done;
        logic       cur_nil;
        logic       key_hit;
        logic       full;
        logic       idx_zero;
        logic       less;
        logic       idx_lt_cnt;
        logic       srt_eq;
        logic       idx1_lt_cnt;
        logic       pos_ok;
        logic       out_free;
    } t_stat;

endpackage

[hw/rtl/chm_ctrl.sv]
// chm_ctrl: sequencer for the hash map core, issues one micro-op per cycle
// depends on chm_pkg (t_cmd, t_stat, op and status codes)
module chm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_cfg_valid,
    input  chm_pkg::t_stat i_st,
    output chm_pkg::t_cmd o_cmd,
    output logic          o_stall,
    output logic          o_cfg_ready
);
    import chm_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_START  = 5'd1;
    localparam logic [4:0] S_DIV    = 5'd2;
    localparam logic [4:0] S_HTAKE  = 5'd3;
    localparam logic [4:0] S_WALK   = 5'd4;
    localparam logic [4:0] S_ECHK   = 5'd5;
    localparam logic [4:0] S_HIT    = 5'd6;
    localparam logic [4:0] S_MISS   = 5'd7;
    localparam logic [4:0] S_ALLOC  = 5'd8;
    localparam logic [4:0] S_IRD    = 5'd9;
    localparam logic [4:0] S_ICHK   = 5'd10;
    localparam logic [4:0] S_IPUT   = 5'd11;
    localparam logic [4:0] S_SRD    = 5'd12;
    localparam logic [4:0] S_SCHK   = 5'd13;
    localparam logic [4:0] S_NRD    = 5'd14;
    localparam logic [4:0] S_SHIFT  = 5'd15;
    localparam logic [4:0] S_PTAKE  = 5'd16;
    localparam logic [4:0] S_DONE   = 5'd17;

    logic [4:0] r_state, n_state;
    logic       r_found, n_found;
    logic [2:0] r_status, n_status;
    logic       idle;

    assign idle        = (r_state == S_IDLE);
    assign o_stall     = !idle;
    assign o_cfg_ready = idle;

    // next state and micro-op
    always_comb begin
        n_state  = r_state;
        n_found  = r_found;
        n_status = r_status;
        o_cmd            = '0;
        o_cmd.op         = OP_NONE;
        o_cmd.cfg_we     = i_cfg_valid && idle;
        o_cmd.res_found  = r_found;
        o_cmd.res_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_START;
                end
            end
            S_START: begin
                if (i_st.func == FN_READ) begin
                    if (i_st.pos_ok) begin
                        o_cmd.op = OP_POS_RD;
                        n_state  = S_PTAKE;
                    end else begin
                        n_found  = 1'b0;
                        n_status = ST_RANGE;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_state = S_DIV;
                end
            end
            S_PTAKE: begin
                o_cmd.op = OP_POS_TAKE;
                n_state  = S_DIV;
            end
            S_DIV: begin
                if (i_st.div_done) begin
                    o_cmd.op = OP_HEAD_RD;
                    n_state  = S_HTAKE;
                end else begin
                    o_cmd.op = OP_DIV;
                end
            end
            S_HTAKE: begin
                o_cmd.op = OP_HEAD_TAKE;
                n_state  = S_WALK;
            end
            S_WALK: begin
                if (i_st.cur_nil) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.op = OP_ENT_RD;
                    n_state  = S_ECHK;
                end
            end
            S_ECHK: begin
                o_cmd.op = OP_ENT_CHK;
                n_state  = i_st.key_hit ? S_HIT : S_WALK;
            end
            S_HIT: begin
                n_found  = 1'b1;
                n_status = ST_OK;
                n_state  = S_DONE;
                case (i_st.func)
                    FN_ENTER:  n_status = ST_PRESENT;
                    FN_REMOVE: begin
                        o_cmd.op = OP_UNLINK;
                        n_state  = S_SRD;
                    end
                    default: ;
                endcase
            end
            S_MISS: begin
                n_found  = 1'b0;
                n_status = ST_NOTFOUND;
                n_state  = S_DONE;
                case (i_st.func)
                    FN_ENTER: begin
                        if (i_st.full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_OK;
                            o_cmd.op = OP_ALLOC_RD;
                            n_state  = S_ALLOC;
                        end
                    end
                    FN_READ: begin
                        n_found  = 1'b1;
                        n_status = ST_OK;
                    end
                    default: ;
                endcase
            end
            S_ALLOC: begin
                o_cmd.op = OP_ALLOC;
                n_state  = S_IRD;
            end
            S_IRD: begin
                if (i_st.idx_zero) begin
                    n_state = S_IPUT;
                end else begin
                    o_cmd.op = OP_SRT_RD;
                    n_state  = S_ICHK;
                end
            end
            S_ICHK: begin
                o_cmd.op = OP_INS_CHK;
                n_state  = i_st.less ? S_IRD : S_IPUT;
            end
            S_IPUT: begin
                o_cmd.op = OP_INS_PUT;
                n_state  = S_DONE;
            end
            S_SRD: begin
                if (i_st.idx_lt_cnt) begin
                    o_cmd.op = OP_SRT_RD_I;
                    n_state  = S_SCHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCHK: begin
                o_cmd.op = OP_SRCH_CHK;
                n_state  = i_st.srt_eq ? S_NRD : S_SRD;
            end
            S_NRD: begin
                if (i_st.idx1_lt_cnt) begin
                    o_cmd.op = OP_SRT_RD_N;
                    n_state  = S_SHIFT;
                end else begin
                    o_cmd.op = OP_DEC;
                    n_state  = S_DONE;
                end
            end
            S_SHIFT: begin
                o_cmd.op = OP_SHIFT_DN;
                n_state  = S_NRD;
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.op = OP_DONE;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_found  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_found  <= n_found;
            r_status <= n_status;
        end
    end

endmodule

[hw/rtl/chm_dpath.sv]
// chm_dpath: tables, hash divider, chain walker, sorted list and result register
// depends on chm_pkg (t_cmd, t_stat, op codes)
module chm_dpath #(
    parameter int BUCKETS  = 64,
    parameter int CAPACITY = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  chm_pkg::t_cmd i_cmd,
    input  logic [1:0]    i_func,
    input  logic [31:0]   i_key,
    input  logic [31:0]   i_data_in,
    input  logic [7:0]    i_position,
    input  logic [6:0]    i_cfg_data,
    input  logic          i_out_stall,
    output chm_pkg::t_stat o_st,
    output logic          o_valid,
    output logic          o_found,
    output logic [31:0]   o_key_out,
    output logic [31:0]   o_data_out,
    output logic [2:0]    o_status,
    output logic [8:0]    o_entry_count
);
    import chm_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int HW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int MW = $clog2(BUCKETS + 1);
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);
    localparam int BC_RST = (BUCKETS > 127) ? 127 : BUCKETS;

    // storage
    logic [31:0]   m_ekey  [CAPACITY];
    logic [31:0]   m_edata [CAPACITY];
    logic [PW-1:0] m_enext [CAPACITY];
    logic [PW-1:0] m_flink [CAPACITY];
    logic [31:0]   m_srt   [CAPACITY];
    logic [PW-1:0] m_bhead [BUCKETS];
    logic [BUCKETS-1:0] r_bvalid;

    logic [31:0]   r_ekey_q, r_edata_q, r_srt_q;
    logic [PW-1:0] r_enext_q, r_flink_q, r_bhead_q;

    // operation registers
    logic [1:0]    r_func;
    logic [31:0]   r_key, r_din, r_kout, r_dout;
    logic [7:0]    r_pos;
    logic [6:0]    r_bc;
    logic [MW-1:0] r_mod, r_rem;
    logic [31:0]   r_prod;
    logic [5:0]    r_divcnt;
    logic [PW-1:0] r_cnt, r_free_head, r_fresh;
    logic [PW-1:0] r_cur, r_prev, r_steps, r_hit, r_next, r_head0, r_idx;
    logic          r_prev_head;

    // result register
    logic          r_ovalid, r_o_found;
    logic [31:0]   r_o_kout, r_o_dout;
    logic [2:0]    r_o_status;
    logic [8:0]    r_o_cnt;

    logic [HW-1:0] hash;
    logic [MW-1:0] mod_c;
    logic [MW:0]   trial, diff;
    logic [PW-1:0] srt_ra;
    logic          out_free;

    assign hash     = r_rem[HW-1:0];
    assign out_free = !r_ovalid || !i_out_stall;

    // clamp bucket count into 1..BUCKETS
    always_comb begin
        if (r_bc == 7'd0) begin
            mod_c = MW'(1);
        end else if (32'(r_bc) > 32'(BUCKETS)) begin
            mod_c = MW'(BUCKETS);
        end else begin
            mod_c = MW'(r_bc);
        end
    end

    // one restoring division step
    assign trial = {r_rem, r_prod[31]};
    assign diff  = trial - {1'b0, r_mod};

    // sorted list read address
    always_comb begin
        case (i_cmd.op)
            OP_SRT_RD:   srt_ra = r_idx - PW'(1);
            OP_SRT_RD_N: srt_ra = r_idx + PW'(1);
            OP_POS_RD:   srt_ra = PW'(r_pos);
            default:     srt_ra = r_idx;
        endcase
    end

    // status to the controller
    always_comb begin
        o_st.func        = r_func;
        o_st.div_done    = (r_divcnt == 6'd32);
        o_st.cur_nil     = (r_cur >= NIL) || (r_steps >= NIL);
        o_st.key_hit     = (r_ekey_q == r_key);
        o_st.full        = (r_free_head >= NIL) || (r_cnt >= NIL);
        o_st.idx_zero    = (r_idx == '0);
        o_st.less        = ($signed(r_key) < $signed(r_srt_q));
        o_st.idx_lt_cnt  = (r_idx < r_cnt);
        o_st.srt_eq      = (r_srt_q == r_key);
        o_st.idx1_lt_cnt = (({1'b0, r_idx} + (PW+1)'(1)) < {1'b0, r_cnt});
        o_st.pos_ok      = (32'(r_pos) < 32'(r_cnt));
        o_st.out_free    = out_free;
    end

    // entry tables
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ALLOC) begin
            m_ekey[r_free_head[AW-1:0]]  <= r_key;
            m_edata[r_free_head[AW-1:0]] <= r_din;
            m_enext[r_free_head[AW-1:0]] <= r_head0;
        end else if (i_cmd.op == OP_UNLINK && !r_prev_head) begin
            m_enext[r_prev[AW-1:0]] <= r_next;
        end
        r_ekey_q  <= m_ekey[r_cur[AW-1:0]];
        r_edata_q <= m_edata[r_cur[AW-1:0]];
        r_enext_q <= m_enext[r_cur[AW-1:0]];
    end

    // free list links
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_UNLINK) begin
            m_flink[r_hit[AW-1:0]] <= r_free_head;
        end
        r_flink_q <= m_flink[r_free_head[AW-1:0]];
    end

    // bucket heads
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ALLOC) begin
            m_bhead[hash] <= r_free_head;
        end else if (i_cmd.op == OP_UNLINK && r_prev_head) begin
            m_bhead[hash] <= r_next;
        end
        r_bhead_q <= m_bhead[hash];
    end

    // sorted key list
    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == OP_INS_CHK && o_st.less) || i_cmd.op == OP_SHIFT_DN) begin
            m_srt[r_idx[AW-1:0]] <= r_srt_q;
        end else if (i_cmd.op == OP_INS_PUT) begin
            m_srt[r_idx[AW-1:0]] <= r_key;
        end
        r_srt_q <= m_srt[srt_ra[AW-1:0]];
    end

    // payload registers of the running operation
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_func   <= i_func;
                r_key    <= i_key;
                r_din    <= i_data_in;
                r_pos    <= i_position;
                r_kout   <= i_key;
                r_dout   <= '0;
                r_prod   <= {i_key[27:0], 4'b0} + i_key;
                r_rem    <= '0;
                r_divcnt <= '0;
                r_mod    <= mod_c;
            end
            OP_POS_TAKE: begin
                r_key    <= r_srt_q;
                r_kout   <= r_srt_q;
                r_prod   <= {r_srt_q[27:0], 4'b0} + r_srt_q;
                r_rem    <= '0;
                r_divcnt <= '0;
            end
            OP_DIV: begin
                r_rem    <= (trial >= {1'b0, r_mod}) ? diff[MW-1:0] : trial[MW-1:0];
                r_prod   <= {r_prod[30:0], 1'b0};
                r_divcnt <= r_divcnt + 6'd1;
            end
            OP_HEAD_TAKE: begin
                r_cur       <= r_bvalid[hash] ? r_bhead_q : NIL;
                r_head0     <= r_bvalid[hash] ? r_bhead_q : NIL;
                r_prev_head <= 1'b1;
                r_steps     <= '0;
            end
            OP_ENT_CHK: begin
                if (o_st.key_hit) begin
                    r_dout <= r_edata_q;
                    r_hit  <= r_cur;
                    r_next <= r_enext_q;
                end else begin
                    r_prev      <= r_cur;
                    r_prev_head <= 1'b0;
                    r_cur       <= r_enext_q;
                    r_steps     <= r_steps + PW'(1);
                end
            end
            default: ;
        endcase
    end

    // control state: pool, counts, bucket valid bits, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc        <= 7'(BC_RST);
            r_bvalid    <= '0;
            r_fresh     <= '0;
            r_free_head <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_ALLOC: begin
                    r_bvalid[hash] <= 1'b1;
                    r_idx          <= r_cnt;
                    if (r_free_head == r_fresh) begin
                        r_free_head <= r_fresh + PW'(1);
                        r_fresh     <= r_fresh + PW'(1);
                    end else begin
                        r_free_head <= r_flink_q;
                    end
                end
                OP_INS_CHK: begin
                    if (o_st.less) r_idx <= r_idx - PW'(1);
                end
                OP_INS_PUT: r_cnt <= r_cnt + PW'(1);
                OP_UNLINK: begin
                    if (r_prev_head) r_bvalid[hash] <= 1'b1;
                    r_free_head <= r_hit;
                    r_idx       <= '0;
                end
                OP_SRCH_CHK: begin
                    if (!o_st.srt_eq) r_idx <= r_idx + PW'(1);
                end
                OP_SHIFT_DN: r_idx <= r_idx + PW'(1);
                OP_DEC:      r_cnt <= r_cnt - PW'(1);
                default: ;
            endcase
            // output beat handoff
            if (i_cmd.op == OP_DONE) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            // bucket count write empties the map
            if (i_cmd.cfg_we) begin
                r_bc        <= i_cfg_data;
                r_bvalid    <= '0;
                r_fresh     <= '0;
                r_free_head <= '0;
                r_cnt       <= '0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_DONE) begin
            r_o_found  <= i_cmd.res_found;
            r_o_kout   <= r_kout;
            r_o_dout   <= r_dout;
            r_o_status <= i_cmd.res_status;
            r_o_cnt    <= 9'(r_cnt);
        end
    end

    assign o_valid       = r_ovalid;
    assign o_found       = r_o_found;
    assign o_key_out     = r_o_kout;
    assign o_data_out    = r_o_dout;
    assign o_status      = r_o_status;
    assign o_entry_count = r_o_cnt;

endmodule

[hw/rtl/chained_hash_map_with_sorted_keys_core.sv]
// chained_hash_map_with_sorted_keys_core: top level of the hash map with sorted keys
// depends on chm_pkg, chm_ctrl, chm_dpath
//
//  channel   handshake                 beat payload
//  input     i_valid / o_stall         i_func, i_key, i_data_in, i_position
//  output    o_valid / i_stall         o_found, o_key_out, o_data_out, o_status,
//                                      o_entry_count
//  config    i_cfg_valid / o_cfg_ready i_cfg_data (bucket_count)
//
// one operation at a time; the key goes through the 32-step hash divider, then the bucket
// head is read and the chain is walked entry by entry; enter also scans the sorted key
// list from the top to insert, remove scans it and shifts the keys behind the removed one
// down, and read ordered first reads the key at the given position or ends if out of range.
// synchronous active-low reset empties the map, no clearing pass.
// a stalled output holds its beat; the next input beat is taken meanwhile.
module chained_hash_map_with_sorted_keys_core #(
    parameter int BUCKETS  = 64,
    parameter int CAPACITY = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_key,
    input  logic [31:0]        i_data_in,
    input  logic [7:0]         i_position,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_found,
    output logic signed [31:0] o_key_out,
    output logic [31:0]        o_data_out,
    output logic [2:0]         o_status,
    output logic [8:0]         o_entry_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [6:0]         i_cfg_data
);
    import chm_pkg::*;

    t_cmd        cmd;
    t_stat       st;
    logic [31:0] key_out;

    // sequencer
    chm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_st        (st),
        .o_cmd       (cmd),
        .o_stall     (o_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    // tables and arithmetic
    chm_dpath #(
        .BUCKETS  (BUCKETS),
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (i_func),
        .i_key         (i_key),
        .i_data_in     (i_data_in),
        .i_position    (i_position),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_stall),
        .o_st          (st),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_key_out     (key_out),
        .o_data_out    (o_data_out),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    assign o_key_out = key_out;

`ifndef NO_ASSERTIONS
    // an accepted beat keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accept");

    // configuration only taken while no operation runs
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> !o_stall)
        else $error("config write while busy");

    // key count never exceeds the pool
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_entry_count) <= 32'(CAPACITY)))
        else $error("entry count above capacity");

    // a finished result is never reported as out of range with found set
    a_range_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_RANGE) |-> !o_found)
        else $error("range status with found set");
`endif

endmodule

[tb/tb_chained_hash_map_with_sorted_keys_core.sv]
// testbench for chained_hash_map_with_sorted_keys_core: drives map operations, predicts
// each result beat from a behavioral copy of the table, checks the whole beat at once
// depends on chm_pkg and the core rtl
module tb_chained_hash_map_with_sorted_keys_core;
    timeunit 1ns;
    timeprecision 1ps;
    import chm_pkg::*;

    localparam int BUCKETS  = 64;
    localparam int CAPACITY = 256;

    typedef struct packed {
        logic        found;
        logic [31:0] key_out;
        logic [31:0] data_out;
        logic [2:0]  status;
        logic [8:0]  entry_count;
    } t_map_result;

    // behavioral map: contents plus sorted key list
    class map_scoreboard;
        int unsigned modulus;
        logic [31:0] keys_sorted[$];
        logic [31:0] data_of[logic [31:0]];
        t_map_result pending[$];
        int mismatches;

        function new();
            modulus = BUCKETS;
            mismatches = 0;
        endfunction

        function void set_buckets(logic [6:0] v);
            modulus = v;
            keys_sorted.delete();
            data_of.delete();
        endfunction

        // predict the result beat of one accepted operation
        function void note_op(logic [1:0] fn, logic [31:0] k, logic [31:0] d,
                              logic [7:0] pos);
            t_map_result r;
            int i;
            r = '0;
            r.key_out = k;
            case (fn)
                FN_FIND: begin
                    if (data_of.exists(k)) begin
                        r.found = 1; r.data_out = data_of[k]; r.status = ST_OK;
                    end else r.status = ST_NOTFOUND;
                end
                FN_ENTER: begin
                    if (data_of.exists(k)) begin
                        r.found = 1; r.data_out = data_of[k]; r.status = ST_PRESENT;
                    end else if (keys_sorted.size() >= CAPACITY) r.status = ST_FULL;
                    else begin
                        data_of[k] = d;
                        i = 0;
                        while (i < keys_sorted.size() &&
                               $signed(keys_sorted[i]) < $signed(k)) i++;
                        keys_sorted.insert(i, k);
                        r.status = ST_OK;
                    end
                end
                FN_REMOVE: begin
                    if (data_of.exists(k)) begin
                        r.found = 1; r.data_out = data_of[k]; r.status = ST_OK;
                        data_of.delete(k);
                        for (i = 0; i < keys_sorted.size(); i++)
                            if (keys_sorted[i] == k) break;
                        keys_sorted.delete(i);
                    end else r.status = ST_NOTFOUND;
                end
                default: begin
                    if (pos < keys_sorted.size()) begin
                        r.found = 1;
                        r.key_out = keys_sorted[pos];
                        r.data_out = data_of[keys_sorted[pos]];
                        r.status = ST_OK;
                    end else r.status = ST_RANGE;
                end
            endcase
            r.entry_count = keys_sorted.size();
            pending.push_back(r);
        endfunction

        function void check_beat(t_map_result got);
            t_map_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        in_valid, out_stall_in;
    logic [1:0]  func;
    logic [31:0] key, data_in;
    logic [7:0]  position;
    logic        cfg_valid;
    logic [6:0]  cfg_data;
    logic        o_stall, o_valid, o_found, o_cfg_ready;
    logic [31:0] o_key_out, o_data_out;
    logic [2:0]  o_status;
    logic [8:0]  o_entry_count;

    map_scoreboard sb;
    int  cycles;
    bit  idling_on;
    bit  hold_off;
    int  ops_sent;
    logic [31:0] key_pool[$];

    chained_hash_map_with_sorted_keys_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(o_stall),
        .i_func(func), .i_key(key), .i_data_in(data_in), .i_position(position),
        .o_valid(o_valid), .i_stall(out_stall_in),
        .o_found(o_found), .o_key_out(o_key_out), .o_data_out(o_data_out),
        .o_status(o_status), .o_entry_count(o_entry_count),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("tb_chained_hash_map_with_sorted_keys_core: done, errors");
            $finish;
        end
    end

    // output side: check beats, random stall bursts, one long hold-off
    initial begin
        int n;
        out_stall_in = 0;
        @(posedge clk);
        forever begin
            if (hold_off) begin
                out_stall_in <= 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 10);
                out_stall_in <= 1;
                repeat (n) @(posedge clk);
            end else begin
                out_stall_in <= 0;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
        if (rst_n && o_valid && !out_stall_in)
            sb.check_beat({o_found, o_key_out, o_data_out, o_status, o_entry_count});

    // send one operation beat and wait for acceptance; valid stays up afterwards unless idling gaps are on
    task automatic send_op(logic [1:0] fn, logic [31:0] k, logic [31:0] d, logic [7:0] p);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1; func <= fn; key <= k; data_in <= d; position <= p;
        do @(posedge clk); while (o_stall);
        sb.note_op(fn, k, d, p);
        ops_sent++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge clk); guard++;
        end
        repeat (100) @(posedge clk);
    endtask

    // write bucket_count while idle
    task automatic set_buckets(logic [6:0] v);
        drain();
        cfg_valid <= 1; cfg_data <= v;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 0;
        sb.set_buckets(v);
        key_pool.delete();
    endtask

    function automatic logic [31:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(0, 2) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return (($urandom_range(0, 1) != 0) ? $urandom_range(0, 40) - 20 : $urandom());
    endfunction

    // one random phase of n operations
    task automatic random_phase(int n);
        logic [1:0] fn;
        logic [31:0] k;
        repeat (n) begin
            fn = $urandom_range(0, 3);
            k = pick_key();
            if (fn == FN_ENTER) key_pool.push_back(k);
            send_op(fn, k, $urandom(), (fn == FN_READ && $urandom_range(0, 5) == 0) ?
                    8'($urandom()) : 8'($urandom_range(0, sb.keys_sorted.size() + 1)));
        end
    endtask

    initial begin
        sb = new();
        cycles = 0; ops_sent = 0; idling_on = 0; hold_off = 0;
        rst_n = 0; in_valid = 0; func = FN_FIND; key = 0; data_in = 0; position = 0;
        cfg_valid = 0; cfg_data = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every operation, duplicates, range errors
        send_op(FN_FIND, 32'h8000_0000, 0, 0);
        send_op(FN_READ, 0, 0, 0);
        send_op(FN_ENTER, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        send_op(FN_ENTER, 32'h8000_0000, 32'h0, 0);
        send_op(FN_ENTER, 32'h0, 32'h5555_AAAA, 0);
        send_op(FN_ENTER, 32'hFFFF_FFFF, 32'hAAAA_5555, 0);
        send_op(FN_ENTER, 32'h0, 32'h1234, 0);
        send_op(FN_READ, 0, 0, 0);
        send_op(FN_READ, 0, 0, 3);
        send_op(FN_READ, 32'h1357, 0, 4);
        send_op(FN_READ, 32'hFFFF_0000, 0, 8'hFF);
        send_op(FN_FIND, 32'h7FFF_FFFF, 0, 0);
        send_op(FN_REMOVE, 32'h8000_0000, 0, 0);
        send_op(FN_REMOVE, 32'h8000_0000, 0, 0);
        send_op(FN_READ, 0, 0, 0);
        send_op(FN_ENTER, 32'h8000_0000, 32'h77, 0);
        send_op(FN_READ, 0, 0, 0);

        // single bucket: long chains, fill to capacity then overflow
        set_buckets(7'd1);
        for (int i = 0; i < 258; i++) send_op(FN_ENTER, i * 3 - 300, $urandom(), 0);
        send_op(FN_READ, 0, 0, 8'hFF);
        send_op(FN_REMOVE, -300, 0, 0);
        send_op(FN_ENTER, 32'h7FFF_0000, 32'hDEAD, 0);

        // back-pressure: hold output while input keeps offering
        set_buckets(7'd0);
        hold_off = 1;
        random_phase(20);

        idling_on = 1;
        set_buckets(7'd64);
        random_phase(150);
        set_buckets(7'd127);
        random_phase(100);
        set_buckets(7'd13);
        random_phase(100);
        set_buckets(7'd2);
        random_phase(50);
        idling_on = 0;
        set_buckets(7'd37);
        random_phase(60);

        drain();
        $display("covered %0d operations over bucket counts 64,1,0,127,13,2,37", ops_sent);
        $display("including a full table, overflow and a long output hold-off");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_chained_hash_map_with_sorted_keys_core: done, clean");
        else
            $display("tb_chained_hash_map_with_sorted_keys_core: done, errors");
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/chm_pkg.sv
hw/rtl/chm_ctrl.sv
hw/rtl/chm_dpath.sv
hw/rtl/chained_hash_map_with_sorted_keys_core.sv
tb/tb_chained_hash_map_with_sorted_keys_core.sv
